// File: rtl/abp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abp_pkg
// Shared constants, types and helpers for the any-base string parser.
// ----------------------------------------------------------------------------
package abp_pkg;

  // digit table depth and derived widths
  localparam int MAX_DIGITS = 64;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int POS_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CHAR_W     = 8;
  localparam int ACC_W      = 32;

  // character codes
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;

  // smallest usable radix
  localparam logic [CNT_W-1:0] MIN_RADIX = CNT_W'(2);

  // item modes
  localparam logic MODE_BASE   = 1'b0;
  localparam logic MODE_STRING = 1'b1;

  // result of a lookup across the cell row
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] idx;
  } lookup_t;

  // whitespace and sign characters
  function automatic logic is_skip_char(input logic [CHAR_W-1:0] c);
    is_skip_char = (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_SPACE) ||
                   ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// File: rtl/atoi_any_base_parser.sv
`timescale 1ns / 1ps
// A string's result is registered when its last item is accepted; it is
// presented at out_valid on the next cycle and held until taken.
// Throughput: one item per cycle while in_ready is high, set by the lookup
// across the cell row followed by the accumulator multiply-add.
// Reset (rst_n, synchronous): empty table, base invalid, parser rearmed;
// digit cells keep undefined bytes, masked by the digit count.
// ----------------------------------------------------------------------------
// atoi_any_base_parser
// Loads a digit table one byte at a time and parses signed strings in the
// radix that table defines, giving one result per string.
// ----------------------------------------------------------------------------
module atoi_any_base_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [7:0]         in_char_code,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic               out_base_valid
);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [abp_pkg::CNT_W-1:0]      digit_count_r, digit_count_nxt;
  logic                           table_good_r, table_good_nxt;
  logic                           table_restart_r, table_restart_nxt;
  logic                           negative_r, negative_nxt;
  logic [abp_pkg::ACC_W-1:0]      acc_r, acc_nxt;

  logic                           out_valid_r;
  logic                           out_good_r;
  logic                           out_neg_r;
  logic [abp_pkg::ACC_W-1:0]      out_acc_r;

  logic                           fire;
  logic                           emit;
  logic [abp_pkg::CNT_W-1:0]      eff_count;
  logic [abp_pkg::CNT_W-1:0]      cmp_count;
  logic                           store;
  logic                           bad_byte;
  abp_pkg::lookup_t               lookup;
  logic [abp_pkg::ACC_W+abp_pkg::CNT_W-1:0] mul_full;
  logic [abp_pkg::ACC_W-1:0]      mac;
  logic [abp_pkg::ACC_W-1:0]      acc_item;
  logic                           neg_item;

  // handshake: output register frees the input side
  assign fire     = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign emit     = fire && (in_mode == abp_pkg::MODE_STRING) && in_last;

  // a restarting base starts from an empty table
  assign eff_count = table_restart_r ? '0 : digit_count_r;
  assign cmp_count = (in_mode == abp_pkg::MODE_BASE) ? eff_count : digit_count_r;

  // base byte checks
  assign bad_byte = abp_pkg::is_skip_char(in_char_code) ||
                    (in_char_code == abp_pkg::CH_NUL) || lookup.hit ||
                    (eff_count >= abp_pkg::CNT_W'(abp_pkg::MAX_DIGITS));
  assign store    = fire && (in_mode == abp_pkg::MODE_BASE) && !bad_byte;

  abp_chain u_chain (
    .clk        (clk),
    .shift_en   (store),
    .shift_byte (in_char_code),
    .cmp_byte   (in_char_code),
    .count      (cmp_count),
    .lookup     (lookup)
  );

  // accumulator multiply-add with 32-bit wrap
  assign mul_full = {{abp_pkg::CNT_W{1'b0}}, acc_r} *
                    {{abp_pkg::ACC_W{1'b0}}, digit_count_r};
  assign mac      = mul_full[abp_pkg::ACC_W-1:0] + abp_pkg::ACC_W'(lookup.idx);

  // next state for one item
  always_comb begin
    phase_nxt         = phase_r;
    digit_count_nxt   = digit_count_r;
    table_good_nxt    = table_good_r;
    table_restart_nxt = table_restart_r;
    negative_nxt      = negative_r;
    acc_nxt           = acc_r;
    acc_item          = acc_r;
    neg_item          = negative_r;
    if (fire) begin
      unique case (in_mode)
        abp_pkg::MODE_BASE: begin
          digit_count_nxt   = eff_count + abp_pkg::CNT_W'(store);
          table_good_nxt    = (table_restart_r || table_good_r) && !bad_byte &&
                              !(in_last && (digit_count_nxt < abp_pkg::MIN_RADIX));
          table_restart_nxt = in_last;
        end
        default: begin
          // prefix, digits, then ignore until the last byte
          priority if (phase_r == PH_SKIP && abp_pkg::is_skip_char(in_char_code)) begin
            if (in_char_code == abp_pkg::CH_MINUS) begin
              neg_item = !negative_r;
            end
          end else if (phase_r == PH_SKIP || phase_r == PH_DIGITS) begin
            if (lookup.hit) begin
              acc_item  = mac;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE;
            end
          end else begin
            phase_nxt = phase_r;
          end
          acc_nxt      = acc_item;
          negative_nxt = neg_item;
          // rearm after the string
          if (in_last) begin
            phase_nxt    = PH_SKIP;
            negative_nxt = 1'b0;
            acc_nxt      = '0;
          end
        end
      endcase
    end
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_SKIP;
      digit_count_r   <= '0;
      table_good_r    <= 1'b0;
      table_restart_r <= 1'b1;
      negative_r      <= 1'b0;
      acc_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      digit_count_r   <= digit_count_nxt;
      table_good_r    <= table_good_nxt;
      table_restart_r <= table_restart_nxt;
      negative_r      <= negative_nxt;
      acc_r           <= acc_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, zeroed for an invalid base
  always_ff @(posedge clk) begin
    if (emit) begin
      out_good_r <= table_good_r && table_restart_r;
      out_neg_r  <= neg_item && table_good_r && table_restart_r;
      out_acc_r  <= (table_good_r && table_restart_r) ? acc_item : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_base_valid = out_good_r;
  assign out_value      = out_neg_r ? signed'(abp_pkg::ACC_W'(0) - out_acc_r)
                                    : signed'(out_acc_r);

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    digit_count_r <= abp_pkg::CNT_W'(abp_pkg::MAX_DIGITS))
    else $error("digit count above table depth");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    lookup.hit |-> (abp_pkg::CNT_W'(lookup.idx) < cmp_count))
    else $error("digit index outside loaded table");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("string end did not present a result");

  a_base_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_mode == abp_pkg::MODE_BASE && !out_valid_r) |=> !out_valid_r)
    else $error("base item produced a result");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_good_r) |-> (out_value == 0))
    else $error("invalid base gave nonzero value");

endmodule

// File: rtl/abp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abp_cell
// One digit cell: holds a table byte, passes it on when the row shifts,
// and flags a match against the byte being looked up.
// ----------------------------------------------------------------------------
module abp_cell (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic [abp_pkg::CHAR_W-1:0] shift_in,
  input  logic [abp_pkg::CHAR_W-1:0] cmp_byte,
  output logic [abp_pkg::CHAR_W-1:0] byte_out,
  output logic                       match
);

  logic [abp_pkg::CHAR_W-1:0] byte_r;

  // take the neighbor's byte on a shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= shift_in;
    end
  end

  assign byte_out = byte_r;
  assign match    = (byte_r == cmp_byte);

endmodule

// File: rtl/abp_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abp_chain
// Row of digit cells. New digits enter at cell 0 and push older ones along,
// so cell p holds digit index count-1-p. Returns the matching digit index.
// ----------------------------------------------------------------------------
module abp_chain (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic [abp_pkg::CHAR_W-1:0] shift_byte,
  input  logic [abp_pkg::CHAR_W-1:0] cmp_byte,
  input  logic [abp_pkg::CNT_W-1:0]  count,
  output abp_pkg::lookup_t           lookup
);

  logic [abp_pkg::CHAR_W-1:0]     cell_byte [abp_pkg::MAX_DIGITS];
  logic [abp_pkg::MAX_DIGITS-1:0] cell_match;
  logic [abp_pkg::MAX_DIGITS-1:0] cell_hit;
  logic [abp_pkg::POS_W-1:0]      hit_pos;
  logic [abp_pkg::CNT_W-1:0]      idx_full;

  // cell row, each fed from its left neighbor
  for (genvar g = 0; g < abp_pkg::MAX_DIGITS; g++) begin : g_cell
    localparam logic [abp_pkg::CNT_W-1:0] POS = abp_pkg::CNT_W'(g);
    logic [abp_pkg::CHAR_W-1:0] feed;

    if (g == 0) begin : g_head
      assign feed = shift_byte;
    end else begin : g_body
      assign feed = cell_byte[g-1];
    end

    abp_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .shift_in (feed),
      .cmp_byte (cmp_byte),
      .byte_out (cell_byte[g]),
      .match    (cell_match[g])
    );

    // only occupied cells take part
    assign cell_hit[g] = cell_match[g] && (POS < count);
  end

  // table has no repeats, so at most one hit: or-encode its position
  always_comb begin
    hit_pos = '0;
    for (int k = 0; k < abp_pkg::MAX_DIGITS; k++) begin
      if (cell_hit[k]) begin
        hit_pos = hit_pos | abp_pkg::POS_W'(k);
      end
    end
  end

  // cell position to digit value
  assign idx_full   = count - abp_pkg::CNT_W'(1) - abp_pkg::CNT_W'(hit_pos);
  assign lookup.hit = |cell_hit;
  assign lookup.idx = idx_full[abp_pkg::POS_W-1:0];

endmodule
